[design/cbq_pkg.sv]
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types and constants of the cascaded biquad filter core.
// ----------------------------------------------------------------------------
package cbq_pkg;

   localparam int DEF_NUM_STAGES   = 8;
   localparam int DEF_SAMPLE_WIDTH = 24;
   localparam int DEF_COEF_WIDTH   = 32;

   // Integer bits of the Q4.x coefficient format.
   localparam int COEF_INT_BITS = 4;
   // Width of the active_stages register.
   localparam int ACTIVE_W      = 4;
   // Width of the register index on the configuration port.
   localparam int CSR_INDEX_W   = 3;
   // Guard bits of the section accumulator (five products plus rounding).
   localparam int ACC_GUARD     = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ACTIVE_STAGES = 3'd0,
      REG_FEED_NOW      = 3'd1,
      REG_FEED_PREV     = 3'd2,
      REG_FEED_PREV2    = 3'd3,
      REG_BACK_PREV     = 3'd4,
      REG_BACK_PREV2    = 3'd5
   } csr_index_type;

   // Product terms of one section, in issue order.
   typedef enum logic [2:0] {
      TERM_X    = 3'd0,
      TERM_IN1  = 3'd1,
      TERM_IN2  = 3'd2,
      TERM_OUT1 = 3'd3,
      TERM_OUT2 = 3'd4
   } term_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SAT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     load;      // take a new request sample
      logic     mul;       // issue one product term
      logic     sat;       // finish the section: round, clamp, update history
      logic     out_load;  // move the result into the response register
      term_type term;
   } cmd_type;

endpackage

[design/cbq_ctrl.sv]
// ----------------------------------------------------------------------------
// cbq_ctrl
// Sequencer: walks sections and product terms, owns the response valid.
// ----------------------------------------------------------------------------
module cbq_ctrl
   import cbq_pkg::*;
#(
   parameter int NUM_STAGES = DEF_NUM_STAGES,
   localparam int CNT_W     = $clog2(NUM_STAGES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [CNT_W-1:0] n_stages,
   output logic [CNT_W-1:0] stage,
   output cmd_type          cmd
);

   state_type        state_ff, state_in;
   term_type         term_ff, term_in;
   logic [CNT_W-1:0] stage_ff, stage_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             last_stage;

   assign last_stage = (stage_ff + CNT_W'(1)) == n_stages;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_X;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      stage_in     = stage_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.term     = term_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               term_in  = TERM_X;
               stage_in = '0;
               state_in = (n_stages == '0) ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            if (term_ff == TERM_OUT2) begin
               state_in = ST_SAT;
            end else begin
               term_in = term_type'(term_ff + 3'd1);
            end
         end
         ST_SAT: begin
            cmd.sat = 1'b1;
            term_in = TERM_X;
            if (last_stage) begin
               state_in = ST_DONE;
            end else begin
               stage_in = stage_ff + CNT_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign stage     = stage_ff;
   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while still pending");

   a_last_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAT && last_stage) |=> state_ff == ST_DONE)
      else $error("last section did not finish the request");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && n_stages != '0) |=>
         (state_ff == ST_MUL && term_ff == TERM_X && stage_ff == '0))
      else $error("request did not start at the first term of section zero");

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_SAT) |-> stage_ff < n_stages)
      else $error("section counter beyond active sections");

endmodule

[design/cbq_dp.sv]
// ----------------------------------------------------------------------------
// cbq_dp
// Datapath: configuration, section history, shared multiply-accumulate,
// rounding and saturation, response payload register.
// ----------------------------------------------------------------------------
module cbq_dp
   import cbq_pkg::*;
#(
   parameter int NUM_STAGES   = DEF_NUM_STAGES,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
   localparam int CNT_W       = $clog2(NUM_STAGES + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [COEF_WIDTH-1:0]          csr_wdata,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_clipped,
   input  cmd_type                        cmd,
   input  logic [CNT_W-1:0]               stage,
   output logic [CNT_W-1:0]               n_stages
);

   localparam int IDX_W     = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
   localparam int COEF_FRAC = COEF_WIDTH - COEF_INT_BITS;
   localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_W     = PROD_W + ACC_GUARD;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [ACC_W-1:0] SMAX =
      {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

   logic [ACTIVE_W-1:0]           active_ff;
   logic signed [COEF_WIDTH-1:0]  feed_now_ff, feed_prev_ff, feed_prev2_ff;
   logic signed [COEF_WIDTH-1:0]  back_prev_ff, back_prev2_ff;

   logic signed [SAMPLE_WIDTH-1:0] past_in_1_ff  [NUM_STAGES];
   logic signed [SAMPLE_WIDTH-1:0] past_in_2_ff  [NUM_STAGES];
   logic signed [SAMPLE_WIDTH-1:0] past_out_1_ff [NUM_STAGES];
   logic signed [SAMPLE_WIDTH-1:0] past_out_2_ff [NUM_STAGES];

   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic                           clip_ff;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic                           sub_ff;
   logic signed [ACC_W-1:0]        acc_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_ff;
   logic                           out_clip_ff;

   logic [IDX_W-1:0]               idx;
   logic signed [SAMPLE_WIDTH-1:0] op_sel;
   logic signed [COEF_WIDTH-1:0]   coef_sel;
   logic signed [ACC_W-1:0]        prod_ext, acc_sum, shifted;
   logic                           sat_hi, sat_lo;
   logic signed [SAMPLE_WIDTH-1:0] y;

   // Clamp the section count to the built depth.
   assign n_stages = (32'(active_ff) > NUM_STAGES) ? CNT_W'(NUM_STAGES) : CNT_W'(active_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= ACTIVE_W'(1);
         feed_now_ff   <= '0;
         feed_prev_ff  <= '0;
         feed_prev2_ff <= '0;
         back_prev_ff  <= '0;
         back_prev2_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_ACTIVE_STAGES: active_ff     <= csr_wdata[ACTIVE_W-1:0];
            REG_FEED_NOW:      feed_now_ff   <= csr_wdata;
            REG_FEED_PREV:     feed_prev_ff  <= csr_wdata;
            REG_FEED_PREV2:    feed_prev2_ff <= csr_wdata;
            REG_BACK_PREV:     back_prev_ff  <= csr_wdata;
            REG_BACK_PREV2:    back_prev2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign idx = stage[IDX_W-1:0];

   always_comb begin
      unique case (cmd.term)
         TERM_X: begin
            op_sel   = x_ff;
            coef_sel = feed_now_ff;
         end
         TERM_IN1: begin
            op_sel   = past_in_1_ff[idx];
            coef_sel = feed_prev_ff;
         end
         TERM_IN2: begin
            op_sel   = past_in_2_ff[idx];
            coef_sel = feed_prev2_ff;
         end
         TERM_OUT1: begin
            op_sel   = past_out_1_ff[idx];
            coef_sel = back_prev_ff;
         end
         TERM_OUT2: begin
            op_sel   = past_out_2_ff[idx];
            coef_sel = back_prev2_ff;
         end
         default: begin
            op_sel   = '0;
            coef_sel = '0;
         end
      endcase
   end

   assign prod_in  = op_sel * coef_sel;
   assign prod_ext = {{ACC_GUARD{prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_sum  = sub_ff ? (acc_ff - prod_ext) : (acc_ff + prod_ext);

   // Rounding half was preloaded into the accumulator; only shift and clamp here.
   assign shifted = acc_sum >>> COEF_FRAC;
   assign sat_hi  = shifted > SMAX;
   assign sat_lo  = shifted < SMIN;
   assign y       = sat_hi ? SMAX[SAMPLE_WIDTH-1:0] :
                    sat_lo ? SMIN[SAMPLE_WIDTH-1:0] : shifted[SAMPLE_WIDTH-1:0];

   // Multiply stage; the registered product is accumulated in the next cycle.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_in;
         sub_ff  <= (cmd.term == TERM_OUT1) || (cmd.term == TERM_OUT2);
         if (cmd.term == TERM_X) begin
            acc_ff <= HALF;
         end else begin
            acc_ff <= acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_sample_in;
         clip_ff <= 1'b0;
      end else if (cmd.sat) begin
         x_ff    <= y;
         clip_ff <= clip_ff | sat_hi | sat_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            past_in_1_ff[i]  <= '0;
            past_in_2_ff[i]  <= '0;
            past_out_1_ff[i] <= '0;
            past_out_2_ff[i] <= '0;
         end
      end else if (cmd.sat) begin
         past_in_2_ff[idx]  <= past_in_1_ff[idx];
         past_in_1_ff[idx]  <= x_ff;
         past_out_2_ff[idx] <= past_out_1_ff[idx];
         past_out_1_ff[idx] <= y;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff      <= x_ff;
         out_clip_ff <= clip_ff;
      end
   end

   assign rsp_sample_out = out_ff;
   assign rsp_clipped    = out_clip_ff;

endmodule

[design/cascaded_biquad_filter_core.sv]
// ----------------------------------------------------------------------------
// cascaded_biquad_filter_core
// Cascade of up to NUM_STAGES direct-form-I biquad sections with shared
// coefficients, one shared multiplier, round-to-nearest and saturation.
// ----------------------------------------------------------------------------
// Flow: an accepted request runs through n active sections (n clamped to NUM_STAGES),
//   each with five products on the single multiplier, then a round/clamp step.
// Zero active sections pass the sample as is. Requests run one at a time; the next
//   is taken once the last result sits in the response register.
// Reset: synchronous; one active section, all coefficients zero, history cleared.
// ----------------------------------------------------------------------------
module cascaded_biquad_filter_core
   import cbq_pkg::*;
#(
   parameter int NUM_STAGES   = DEF_NUM_STAGES,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes, to be given only while idle; the user is bound, the block makes no check
   input  logic                           csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [COEF_WIDTH-1:0]          csr_wdata,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_clipped
);

   localparam int CNT_W = $clog2(NUM_STAGES + 1);

   cmd_type          cmd;
   logic [CNT_W-1:0] stage;
   logic [CNT_W-1:0] n_stages;

   // Sequencer: one request at a time, section by section, five terms each.
   // The response register frees the request side as soon as a result lands.
   cbq_ctrl #(
      .NUM_STAGES (NUM_STAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .n_stages  (n_stages),
      .stage     (stage),
      .cmd       (cmd)
   );

   // Datapath: config registers, per-section history, multiply-accumulate,
   // round, clamp and the response payload.
   cbq_dp #(
      .NUM_STAGES   (NUM_STAGES),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .cmd            (cmd),
      .stage          (stage),
      .n_stages       (n_stages)
   );

endmodule

[verif/tb_cascaded_biquad_filter_core.sv]
// ----------------------------------------------------------------------------
// tb_cascaded_biquad_filter_core
// Self-checking bench for the cascaded biquad filter core. A scoreboard class
// runs its own fixed-point cascade on every accepted request sample and
// checks each response in order. A short directed pass covers the sample and
// coefficient extremes and the special stage counts, then random filter
// settings and samples run under three sender/receiver stall profiles.
// ----------------------------------------------------------------------------
module tb_cascaded_biquad_filter_core;
   import cbq_pkg::*;

   localparam int NSTAGE = DEF_NUM_STAGES;
   localparam int SW     = DEF_SAMPLE_WIDTH;
   localparam int CW     = DEF_COEF_WIDTH;
   localparam int FRAC   = CW - COEF_INT_BITS;

   localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   localparam logic signed [SW-1:0] SMAX_IN = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN_IN = {1'b1, {(SW-1){1'b0}}};

   localparam logic signed [CW-1:0] COEF_ONE = 1 << FRAC;
   localparam logic signed [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};

   // Second-order lowpass, Q4.28, feedback terms already in subtracted form.
   localparam logic signed [CW-1:0] LP_A0 = 18119393;
   localparam logic signed [CW-1:0] LP_A1 = 36238786;
   localparam logic signed [CW-1:0] LP_B1 = -306821826;
   localparam logic signed [CW-1:0] LP_B2 = 110810156;

   // Register indexes past the last defined register; writes there are dropped.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam int SETTLE_CYCLES = 2;
   localparam int END_SETTLE    = 6 * NSTAGE + 2;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SEG_SAMPLES   = 30;
   localparam int SEGMENTS      = 5;

   typedef struct packed {
      logic signed [SW-1:0] sample;
      logic                 clipped;
   } biquad_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: holds its own copy of the filter settings and per-section
   // history, predicts each response and checks the responses in order.
   // -------------------------------------------------------------------------
   class biquad_scoreboard;
      logic [ACTIVE_W-1:0]  stage_count;
      logic signed [CW-1:0] gain_now, gain_prev, gain_prev2, fb_prev, fb_prev2;
      logic signed [SW-1:0] hist_in1  [NSTAGE];
      logic signed [SW-1:0] hist_in2  [NSTAGE];
      logic signed [SW-1:0] hist_out1 [NSTAGE];
      logic signed [SW-1:0] hist_out2 [NSTAGE];
      biquad_result_type    expected_out [$];
      int                   samples_in;
      int                   outputs_checked;
      int                   clip_count;
      int                   mismatches;

      function void clear();
         stage_count = ACTIVE_W'(1);
         gain_now    = '0;
         gain_prev   = '0;
         gain_prev2  = '0;
         fb_prev     = '0;
         fb_prev2    = '0;
         for (int i = 0; i < NSTAGE; i++) begin
            hist_in1[i]  = '0;
            hist_in2[i]  = '0;
            hist_out1[i] = '0;
            hist_out2[i] = '0;
         end
         expected_out.delete();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CW-1:0] data);
         case (idx)
            REG_ACTIVE_STAGES: stage_count = data[ACTIVE_W-1:0];
            REG_FEED_NOW:      gain_now    = data;
            REG_FEED_PREV:     gain_prev   = data;
            REG_FEED_PREV2:    gain_prev2  = data;
            REG_BACK_PREV:     fb_prev     = data;
            REG_BACK_PREV2:    fb_prev2    = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_out.size();
      endfunction

      // Run one sample through the active sections and queue the response.
      function void note_sample(logic signed [SW-1:0] sample);
         logic signed [SW-1:0] x;
         logic signed [SW-1:0] y;
         longint               acc;
         int                   n;
         logic                 clip;
         biquad_result_type    want;
         x    = sample;
         clip = 1'b0;
         n    = (stage_count > NSTAGE) ? NSTAGE : int'(stage_count);
         for (int i = 0; i < n; i++) begin
            acc = longint'(x)            * longint'(gain_now)
                + longint'(hist_in1[i])  * longint'(gain_prev)
                + longint'(hist_in2[i])  * longint'(gain_prev2)
                - longint'(hist_out1[i]) * longint'(fb_prev)
                - longint'(hist_out2[i]) * longint'(fb_prev2);
            acc = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
            if (acc > SAMPLE_MAX) begin
               acc  = SAMPLE_MAX;
               clip = 1'b1;
            end else if (acc < SAMPLE_MIN) begin
               acc  = SAMPLE_MIN;
               clip = 1'b1;
            end
            y            = acc[SW-1:0];
            hist_in2[i]  = hist_in1[i];
            hist_in1[i]  = x;
            hist_out2[i] = hist_out1[i];
            hist_out1[i] = y;
            x            = y;
         end
         want.sample  = x;
         want.clipped = clip;
         expected_out.push_back(want);
         samples_in++;
         if (clip)
            clip_count++;
      endfunction

      function void check_output(logic signed [SW-1:0] got, logic got_clip);
         biquad_result_type want;
         if (expected_out.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response with nothing pending: sample %0d clipped %0b",
                        got, got_clip);
            return;
         end
         want = expected_out.pop_front();
         outputs_checked++;
         if (got !== want.sample || got_clip !== want.clipped) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response %0d: sample exp %0d got %0d, clipped exp %0b got %0b",
                        outputs_checked, want.sample, got, want.clipped, got_clip);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero.
   // -------------------------------------------------------------------------
   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   csr_wr_en     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CW-1:0]          csr_wdata     = '0;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic signed [SW-1:0]   req_sample_in = '0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic signed [SW-1:0]   rsp_sample_out;
   logic                   rsp_clipped;

   int                     req_idle_pct    = 0;
   int                     rsp_idle_pct    = 0;
   int                     settings_loaded = 0;
   int                     cycle_count     = 0;
   biquad_scoreboard       sb;

   always #5 clock = ~clock;

   cascaded_biquad_filter_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped)
   );

   // Receiver: stall at random, at the rate the current profile asks for.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Response monitor: values read here are the ones from before this edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_output(rsp_sample_out, rsp_clipped);
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still pending",
                  cycle_count, sb.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus tasks. Every task starts and ends right after a rising edge.
   // -------------------------------------------------------------------------

   // Offer one request sample and hold it until the block takes it. Valid is
   // left high on return so back-to-back requests never toggle it in one step.
   task automatic send_sample(logic signed [SW-1:0] s);
      if (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(s);
   endtask

   // Drop valid and wait until every pending response has been checked, so
   // the block is idle and the settings may change.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write enable stays high; load_filter drops it after the last write.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CW-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic load_filter(logic [ACTIVE_W-1:0] stages,
                              logic [CW-1:0] a0, logic [CW-1:0] a1,
                              logic [CW-1:0] a2, logic [CW-1:0] b1,
                              logic [CW-1:0] b2, bit poke_spare);
      logic [CW-1:0] stage_word;
      // Upper bits of the stage-count write are junk the block must drop.
      stage_word                 = $urandom();
      stage_word[ACTIVE_W-1:0]   = stages;
      write_csr(REG_ACTIVE_STAGES, stage_word);
      write_csr(REG_FEED_NOW,   a0);
      write_csr(REG_FEED_PREV,  a1);
      write_csr(REG_FEED_PREV2, a2);
      write_csr(REG_BACK_PREV,  b1);
      write_csr(REG_BACK_PREV2, b2);
      if (poke_spare) begin
         write_csr(REG_SPARE_LO, $urandom());
         write_csr(REG_SPARE_HI, $urandom());
      end
      csr_wr_en <= 1'b0;
      settings_loaded++;
   endtask

   // Coefficient: any bit pattern when span is zero, else uniform in +-span.
   function automatic logic [CW-1:0] pick_coef(int span);
      logic [CW-1:0] c;
      longint        v;
      if (span == 0) begin
         c = $urandom();
      end else begin
         v = longint'($urandom_range(0, 2 * span)) - span;
         c = v[CW-1:0];
      end
      return c;
   endfunction

   // Sample: mostly full range, some rail values, some tiny values near zero.
   function automatic logic signed [SW-1:0] pick_sample();
      int            r;
      longint        v;
      logic [31:0]   w;
      logic [SW-1:0] s;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         s = $urandom_range(0, 1) ? SMAX_IN : SMIN_IN;
      end else if (r <= 2) begin
         v = longint'($urandom_range(0, 512)) - 256;
         s = v[SW-1:0];
      end else begin
         w = $urandom();
         s = w[SW-1:0];
      end
      return s;
   endfunction

   // Random setting: stage count weighted toward the full cascade, with zero
   // and oversized counts mixed in; coefficients wild, modest or near a lowpass.
   task automatic random_filter();
      int                  pick;
      logic [ACTIVE_W-1:0] stages;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       stages = '0;
         1:       stages = ACTIVE_W'($urandom_range(NSTAGE + 1, (1 << ACTIVE_W) - 1));
         2, 3:    stages = ACTIVE_W'(NSTAGE);
         default: stages = ACTIVE_W'($urandom_range(1, NSTAGE - 1));
      endcase
      case ($urandom_range(0, 3))
         0:       load_filter(stages, pick_coef(0), pick_coef(0), pick_coef(0),
                              pick_coef(0), pick_coef(0), 1'($urandom_range(0, 1)));
         1, 2:    load_filter(stages, pick_coef(1 << 27), pick_coef(1 << 27),
                              pick_coef(1 << 27), pick_coef(1 << 26),
                              pick_coef(1 << 26), 1'b0);
         default: load_filter(stages, LP_A0 + pick_coef(1 << 20),
                              LP_A1 + pick_coef(1 << 20), LP_A0 + pick_coef(1 << 20),
                              LP_B1 + pick_coef(1 << 20), LP_B2 + pick_coef(1 << 20),
                              1'b0);
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Test sequence.
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      sb.clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed pass, light receiver stalls.
      rsp_idle_pct = 30;

      // Reset settings: one section, all gains zero, so rails come out as zero.
      send_sample(SMAX_IN);
      send_sample(SMIN_IN);

      // Unity gain through all eight sections: rails and +-1 LSB pass intact.
      wait_drained();
      load_filter(ACTIVE_W'(NSTAGE), COEF_ONE, '0, '0, '0, '0, 1'b0);
      send_sample('0);
      send_sample(SMAX_IN);
      send_sample(SMIN_IN);
      send_sample(SW'(1));
      send_sample(SW'(-1));

      // Extreme gains and an oversized stage count; also poke the unused
      // register slots. Expect hard clipping in both directions.
      wait_drained();
      load_filter(4'd15, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 1'b1);
      send_sample(SMAX_IN);
      send_sample(SMIN_IN);
      send_sample(SW'(1));
      send_sample(SW'(-1));
      send_sample('0);

      // Zero stages: samples bypass the cascade, history left untouched.
      wait_drained();
      load_filter('0, COEF_MIN, COEF_MAX, COEF_ONE, COEF_MAX, COEF_MIN, 1'b0);
      send_sample(SMAX_IN);
      send_sample(SMIN_IN);
      send_sample(SW'(12345));

      // Three sections of lowpass; sections past the third keep the clipped
      // history from the extreme-gain pass.
      wait_drained();
      load_filter(ACTIVE_W'(3), LP_A0, LP_A1, LP_A0, LP_B1, LP_B2, 1'b0);
      send_sample(SMAX_IN);
      send_sample(SMAX_IN);
      send_sample(SMIN_IN);
      send_sample('0);

      // Reopen all sections on that stale history.
      wait_drained();
      load_filter(ACTIVE_W'(NSTAGE), LP_A0, LP_A1, LP_A0, LP_B1, LP_B2, 1'b0);
      send_sample(SW'(1));
      send_sample(SW'(-1));

      // Random pass: three stall profiles, a fresh filter setting per segment.
      for (int prof = 0; prof < 3; prof++) begin
         case (prof)
            0:       begin req_idle_pct = 9;  rsp_idle_pct = 65; end
            1:       begin req_idle_pct = 65; rsp_idle_pct = 9;  end
            default: begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
         endcase
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            random_filter();
            repeat (SEG_SAMPLES) send_sample(pick_sample());
         end
      end

      wait_drained();
      repeat (END_SETTLE) @(posedge clock);

      $display("Covered %0d request samples over %0d filter settings (stage counts 0 to 15)",
               sb.samples_in, settings_loaded);
      $display("Checked %0d responses, %0d expected clipped, %0d mismatches, %0d left over",
               sb.outputs_checked, sb.clip_count, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[cascaded_biquad_filter_core.f]
design/cbq_pkg.sv
design/cbq_ctrl.sv
design/cbq_dp.sv
design/cascaded_biquad_filter_core.sv
verif/tb_cascaded_biquad_filter_core.sv
